FILE: design/ske_pkg.sv
`timescale 1ns / 1ps

package ske_pkg;

   // Default geometry of the table
   localparam int TABLE_DEPTH_DEF = 64;
   localparam int ID_BITS_DEF     = 64;
   localparam int KEY_BITS_DEF    = 64;

   // Fixed field widths
   localparam int KEY_ID_BITS = 31;
   localparam int STATUS_BITS = 8;
   localparam int CFG_BITS    = 7;

   localparam logic [CFG_BITS-1:0] CFG_RESET = 7'd64;

   // Request kinds
   localparam logic [1:0] KIND_WRITE  = 2'd0;
   localparam logic [1:0] KIND_READ   = 2'd1;
   localparam logic [1:0] KIND_UPDATE = 2'd2;

   // Outcome codes
   localparam logic [1:0] OUTCOME_OK       = 2'd0;
   localparam logic [1:0] OUTCOME_NO_MATCH = 2'd1;
   localparam logic [1:0] OUTCOME_FULL     = 2'd2;

   // Compare unit verdict on one slot
   typedef struct packed {
      logic hit;
      logic empty;
   } cmp_type;

endpackage

FILE: design/ske_ram.sv
`timescale 1ns / 1ps

module ske_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                    wr_data,
   input  logic                                rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                    rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/ske_cmp.sv
`timescale 1ns / 1ps

module ske_cmp #(
   parameter int ID_BITS  = ske_pkg::ID_BITS_DEF,
   parameter int KEY_BITS = ske_pkg::KEY_BITS_DEF
) (
   input  logic [1:0]                       kind,
   input  logic [ID_BITS-1:0]               req_client,
   input  logic [ID_BITS-1:0]               req_server,
   input  logic [ske_pkg::KEY_ID_BITS-1:0]  req_key_id,
   input  logic [ID_BITS-1:0]               ent_client,
   input  logic [ID_BITS-1:0]               ent_server,
   input  logic [ske_pkg::KEY_ID_BITS-1:0]  ent_key_id,
   input  logic [ske_pkg::STATUS_BITS-1:0]  ent_status,
   input  logic [KEY_BITS-1:0]              ent_key,
   output ske_pkg::cmp_type                 result
);

   logic id_match;
   logic kid_match;

   assign id_match  = (ent_client == req_client) && (ent_server == req_server);
   assign kid_match = (ent_key_id == req_key_id);

   always_comb begin
      // a slot is free only when every field is zero
      result.empty = (ent_client == '0) && (ent_server == '0) && (ent_key_id == '0) &&
                     (ent_status == '0) && (ent_key == '0);
      case (kind)
         ske_pkg::KIND_WRITE,
         ske_pkg::KIND_READ: begin
            result.hit = id_match;
         end
         ske_pkg::KIND_UPDATE: begin
            result.hit = kid_match;
         end
         default: begin
            result.hit = 1'b0;
         end
      endcase
   end

endmodule

FILE: design/session_key_table.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_ready  kind, client/server id, key id, status, key
// rsp_      out        rsp_valid/rsp_ready  outcome, fields of the entry found by a read
// csr_      in         csr_valid/csr_ready  entries_in_use (always ready)
//
// Scan: from accept to result, slots 0 .. n-1 are read in order, n = min(entries_in_use, TABLE_DEPTH);
//    then the sequencer returns to idle for the next accept; a hit ends the one-slot-per-cycle scan early.
// Reset: synchronous; a clearing pass then zeroes every slot, with req_ready low.
// Stalls: a finished result waits in the rsp register; the sequencer holds at its finish step
//    only while that register is full, and req_ready stays low until it moves on.
// Writes with no id match take the first all-zero slot seen in the same scan.

module session_key_table #(
   parameter int TABLE_DEPTH = ske_pkg::TABLE_DEPTH_DEF,
   parameter int ID_BITS     = ske_pkg::ID_BITS_DEF,
   parameter int KEY_BITS    = ske_pkg::KEY_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_kind,
   input  logic [ID_BITS-1:0]                  req_client_id,
   input  logic [ID_BITS-1:0]                  req_server_id,
   input  logic [ske_pkg::KEY_ID_BITS-1:0]     req_key_id,
   input  logic [ske_pkg::STATUS_BITS-1:0]     req_status_value,
   input  logic [KEY_BITS-1:0]                 req_key_value,

   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_outcome,
   output logic [ID_BITS-1:0]                  rsp_found_client_id,
   output logic [ID_BITS-1:0]                  rsp_found_server_id,
   output logic [ske_pkg::KEY_ID_BITS-1:0]     rsp_found_key_id,
   output logic [ske_pkg::STATUS_BITS-1:0]     rsp_found_status,
   output logic [KEY_BITS-1:0]                 rsp_found_key_value,

   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ske_pkg::CFG_BITS-1:0]        csr_entries_in_use
);

   localparam int KID_W  = ske_pkg::KEY_ID_BITS;
   localparam int ST_W   = ske_pkg::STATUS_BITS;
   localparam int IDX_W  = TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int LIM_W  = CNT_W > ske_pkg::CFG_BITS ? CNT_W : ske_pkg::CFG_BITS;
   localparam int ENTRY_BITS = 2 * ID_BITS + KID_W + ST_W + KEY_BITS;

   // entry layout: {client, server, key id, status, key}
   localparam int OFF_ST  = KEY_BITS;
   localparam int OFF_KID = OFF_ST + ST_W;
   localparam int OFF_SRV = OFF_KID + KID_W;
   localparam int OFF_CLI = OFF_SRV + ID_BITS;

   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_SCAN   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [ske_pkg::CFG_BITS-1:0] csr_ff, csr_in;

   // captured request
   logic [1:0]          kind_ff, kind_in;
   logic [ID_BITS-1:0]  client_ff, client_in;
   logic [ID_BITS-1:0]  server_ff, server_in;
   logic [KID_W-1:0]    kid_ff, kid_in;
   logic [ST_W-1:0]     status_ff, status_in;
   logic [KEY_BITS-1:0] key_ff, key_in;

   // scan control
   logic [CNT_W-1:0]    n_ff, n_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic [CNT_W-1:0]    cmp_idx_ff, cmp_idx_in;
   logic                pend_ff, pend_in;
   logic                found_ff, found_in;
   logic [CNT_W-1:0]    hit_idx_ff, hit_idx_in;
   logic                empty_seen_ff, empty_seen_in;
   logic [CNT_W-1:0]    empty_idx_ff, empty_idx_in;
   logic [ENTRY_BITS-1:0] entry_ff, entry_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          outcome_ff, outcome_in;
   logic [ENTRY_BITS-1:0] rsp_entry_ff, rsp_entry_in;

   // RAM port signals
   logic                  ram_wr_en;
   logic [IDX_W-1:0]      ram_wr_addr;
   logic [ENTRY_BITS-1:0] ram_wr_data;
   logic                  ram_rd_en;
   logic [ENTRY_BITS-1:0] ram_rd_data;

   ske_pkg::cmp_type cmp;

   logic [LIM_W-1:0]    cfg_wide;
   logic [CNT_W-1:0]    active_cnt;
   logic                accept;
   logic                fin_go;
   logic                issue;

   assign cfg_wide   = LIM_W'(csr_ff);
   assign active_cnt = (cfg_wide > LIM_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                        : CNT_W'(cfg_wide);

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign fin_go    = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);
   assign issue     = (state_ff == ST_SCAN) && !(pend_ff && cmp.hit) && (idx_ff < n_ff);
   assign ram_rd_en = issue;
   assign csr_ready = 1'b1;

   ske_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (idx_ff[IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   ske_cmp #(
      .ID_BITS  (ID_BITS),
      .KEY_BITS (KEY_BITS)
   ) u_cmp (
      .kind       (kind_ff),
      .req_client (client_ff),
      .req_server (server_ff),
      .req_key_id (kid_ff),
      .ent_client (ram_rd_data[OFF_CLI +: ID_BITS]),
      .ent_server (ram_rd_data[OFF_SRV +: ID_BITS]),
      .ent_key_id (ram_rd_data[OFF_KID +: KID_W]),
      .ent_status (ram_rd_data[OFF_ST +: ST_W]),
      .ent_key    (ram_rd_data[KEY_BITS-1:0]),
      .result     (cmp)
   );

   // Sequencer: clear pass, accept, scan one slot per cycle, commit and respond
   always_comb begin
      state_in      = state_ff;
      csr_in        = csr_ff;
      kind_in       = kind_ff;
      client_in     = client_ff;
      server_in     = server_ff;
      kid_in        = kid_ff;
      status_in     = status_ff;
      key_in        = key_ff;
      n_in          = n_ff;
      idx_in        = idx_ff;
      cmp_idx_in    = cmp_idx_ff;
      pend_in       = pend_ff;
      found_in      = found_ff;
      hit_idx_in    = hit_idx_ff;
      empty_seen_in = empty_seen_ff;
      empty_idx_in  = empty_idx_ff;
      entry_in      = entry_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      outcome_in    = outcome_ff;
      rsp_entry_in  = rsp_entry_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = idx_ff[IDX_W-1:0];
      ram_wr_data   = '0;

      if (csr_valid) begin
         csr_in = csr_entries_in_use;
      end

      case (state_ff)
         ST_CLEAR: begin
            // zero one slot per cycle
            ram_wr_en = 1'b1;
            if (idx_ff == CNT_W'(TABLE_DEPTH - 1)) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               kind_in       = req_kind;
               client_in     = req_client_id;
               server_in     = req_server_id;
               kid_in        = req_key_id;
               status_in     = req_status_value;
               key_in        = req_key_value;
               n_in          = active_cnt;
               idx_in        = '0;
               pend_in       = 1'b0;
               found_in      = 1'b0;
               empty_seen_in = 1'b0;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (pend_ff && cmp.hit) begin
               // first match wins; stop here
               found_in   = 1'b1;
               hit_idx_in = cmp_idx_ff;
               entry_in   = ram_rd_data;
               pend_in    = 1'b0;
               state_in   = ST_FINISH;
            end else begin
               if (pend_ff && cmp.empty && !empty_seen_ff) begin
                  empty_seen_in = 1'b1;
                  empty_idx_in  = cmp_idx_ff;
               end
               if (issue) begin
                  pend_in    = 1'b1;
                  cmp_idx_in = idx_ff;
                  idx_in     = idx_ff + 1'b1;
               end else begin
                  pend_in = 1'b0;
                  if (!pend_ff) begin
                     state_in = ST_FINISH;
                  end
               end
            end
         end
         ST_FINISH: begin
            if (fin_go) begin
               rsp_valid_in = 1'b1;
               outcome_in   = ske_pkg::OUTCOME_NO_MATCH;
               rsp_entry_in = '0;
               state_in     = ST_IDLE;
               case (kind_ff)
                  ske_pkg::KIND_WRITE: begin
                     ram_wr_data = {client_ff, server_ff, kid_ff, status_ff, key_ff};
                     if (found_ff) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = hit_idx_ff[IDX_W-1:0];
                        outcome_in  = ske_pkg::OUTCOME_OK;
                     end else if (empty_seen_ff) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = empty_idx_ff[IDX_W-1:0];
                        outcome_in  = ske_pkg::OUTCOME_OK;
                     end else begin
                        outcome_in  = ske_pkg::OUTCOME_FULL;
                     end
                  end
                  ske_pkg::KIND_READ: begin
                     if (found_ff) begin
                        outcome_in   = ske_pkg::OUTCOME_OK;
                        rsp_entry_in = entry_ff;
                     end
                  end
                  ske_pkg::KIND_UPDATE: begin
                     ram_wr_data = entry_ff;
                     ram_wr_data[OFF_ST +: ST_W] = status_ff;
                     ram_wr_addr = hit_idx_ff[IDX_W-1:0];
                     if (found_ff) begin
                        ram_wr_en  = 1'b1;
                        outcome_in = ske_pkg::OUTCOME_OK;
                     end
                  end
                  default: begin
                     outcome_in = ske_pkg::OUTCOME_NO_MATCH;
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         csr_ff        <= ske_pkg::CFG_RESET;
         idx_ff        <= '0;
         pend_ff       <= 1'b0;
         found_ff      <= 1'b0;
         empty_seen_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         csr_ff        <= csr_in;
         idx_ff        <= idx_in;
         pend_ff       <= pend_in;
         found_ff      <= found_in;
         empty_seen_ff <= empty_seen_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload: no reset needed
   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      client_ff    <= client_in;
      server_ff    <= server_in;
      kid_ff       <= kid_in;
      status_ff    <= status_in;
      key_ff       <= key_in;
      n_ff         <= n_in;
      cmp_idx_ff   <= cmp_idx_in;
      hit_idx_ff   <= hit_idx_in;
      empty_idx_ff <= empty_idx_in;
      entry_ff     <= entry_in;
      outcome_ff   <= outcome_in;
      rsp_entry_ff <= rsp_entry_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_outcome         = outcome_ff;
   assign rsp_found_client_id = rsp_entry_ff[OFF_CLI +: ID_BITS];
   assign rsp_found_server_id = rsp_entry_ff[OFF_SRV +: ID_BITS];
   assign rsp_found_key_id    = rsp_entry_ff[OFF_KID +: KID_W];
   assign rsp_found_status    = rsp_entry_ff[OFF_ST +: ST_W];
   assign rsp_found_key_value = rsp_entry_ff[KEY_BITS-1:0];

   // A new result only appears out of the finish step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside finish step");

   // The table is only written while clearing or committing
   assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == ST_CLEAR || state_ff == ST_FINISH))
      else $error("table written during scan or idle");

   // Every compared slot lies inside the active range
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && pend_ff) |-> (cmp_idx_ff < n_ff))
      else $error("compared slot outside active range");

   // A matched slot was really compared in the scan
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && found_ff) |-> (hit_idx_ff < n_ff))
      else $error("matched slot outside active range");

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int DEPTH = ske_pkg::TABLE_DEPTH_DEF;
   localparam int IDW   = ske_pkg::ID_BITS_DEF;
   localparam int KEYW  = ske_pkg::KEY_BITS_DEF;
   localparam int KIDW  = ske_pkg::KEY_ID_BITS;
   localparam int STW   = ske_pkg::STATUS_BITS;
   localparam int CFGW  = ske_pkg::CFG_BITS;

   // The block defines no code for the fourth kind; it must change nothing.
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   // A transaction scans at most DEPTH slots before it finishes.
   localparam int SETTLE_CYCLES   = DEPTH + 16;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int STALL_LIMIT     = 4000;

   typedef struct packed {
      logic [1:0]      kind;
      logic [IDW-1:0]  client_id;
      logic [IDW-1:0]  server_id;
      logic [KIDW-1:0] key_id;
      logic [STW-1:0]  status_value;
      logic [KEYW-1:0] key_value;
   } key_request_type;

   typedef struct packed {
      logic [1:0]      outcome;
      logic [IDW-1:0]  client_id;
      logic [IDW-1:0]  server_id;
      logic [KIDW-1:0] key_id;
      logic [STW-1:0]  status;
      logic [KEYW-1:0] key_value;
   } key_response_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [1:0]             req_kind = ske_pkg::KIND_WRITE;
   logic [IDW-1:0]         req_client_id = '0;
   logic [IDW-1:0]         req_server_id = '0;
   logic [KIDW-1:0]        req_key_id = '0;
   logic [STW-1:0]         req_status_value = '0;
   logic [KEYW-1:0]        req_key_value = '0;

   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [1:0]             rsp_outcome;
   logic [IDW-1:0]         rsp_found_client_id;
   logic [IDW-1:0]         rsp_found_server_id;
   logic [KIDW-1:0]        rsp_found_key_id;
   logic [STW-1:0]         rsp_found_status;
   logic [KEYW-1:0]        rsp_found_key_value;

   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CFGW-1:0]        csr_entries_in_use = ske_pkg::CFG_RESET;

   // Shadow copy of the key table and of the slot count register
   logic [IDW-1:0]         tbl_client [DEPTH];
   logic [IDW-1:0]         tbl_server [DEPTH];
   logic [KIDW-1:0]        tbl_key_id [DEPTH];
   logic [STW-1:0]         tbl_status [DEPTH];
   logic [KEYW-1:0]        tbl_key    [DEPTH];
   logic [CFGW-1:0]        slots_in_use = ske_pkg::CFG_RESET;

   key_request_type        queued_requests[$];
   key_response_type       awaited_responses[$];

   // Ids and key ids already written, so that reads and updates can hit them
   logic [IDW-1:0]         known_clients[$];
   logic [IDW-1:0]         known_servers[$];
   logic [KIDW-1:0]        known_key_ids[$];

   int unsigned            req_offer_count = 0;
   int unsigned            req_accept_count = 0;
   int unsigned            send_idle_pct = 32;
   int unsigned            recv_idle_pct = 61;
   int unsigned            pressure_token = 0;
   int unsigned            pressure_seen = 0;
   int unsigned            hold_left = 0;
   int unsigned            stall_cycles = 0;
   int unsigned            mismatch_count = 0;

   session_key_table dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_kind            (req_kind),
      .req_client_id       (req_client_id),
      .req_server_id       (req_server_id),
      .req_key_id          (req_key_id),
      .req_status_value    (req_status_value),
      .req_key_value       (req_key_value),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_outcome         (rsp_outcome),
      .rsp_found_client_id (rsp_found_client_id),
      .rsp_found_server_id (rsp_found_server_id),
      .rsp_found_key_id    (rsp_found_key_id),
      .rsp_found_status    (rsp_found_status),
      .rsp_found_key_value (rsp_found_key_value),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_entries_in_use  (csr_entries_in_use)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Apply one request to the shadow table and return the response it must produce.
   // Every search covers slots 0 .. n-1 in order and stops at the first hit.
   function automatic key_response_type apply_table_request(key_request_type r);
      key_response_type res;
      int               n;
      int               slot;
      res = '0;
      res.outcome = ske_pkg::OUTCOME_NO_MATCH;
      n = (int'(slots_in_use) > DEPTH) ? DEPTH : int'(slots_in_use);
      slot = -1;
      case (r.kind)
         ske_pkg::KIND_WRITE: begin
            // Overwrite an entry with the same id pair, else take the first empty slot
            for (int i = 0; i < n && slot < 0; i++)
               if (tbl_client[i] == r.client_id && tbl_server[i] == r.server_id)
                  slot = i;
            for (int i = 0; i < n && slot < 0; i++)
               if (tbl_client[i] == '0 && tbl_server[i] == '0 && tbl_key_id[i] == '0 &&
                   tbl_status[i] == '0 && tbl_key[i] == '0)
                  slot = i;
            if (slot >= 0) begin
               tbl_client[slot] = r.client_id;
               tbl_server[slot] = r.server_id;
               tbl_key_id[slot] = r.key_id;
               tbl_status[slot] = r.status_value;
               tbl_key[slot]    = r.key_value;
               res.outcome = ske_pkg::OUTCOME_OK;
            end else begin
               res.outcome = ske_pkg::OUTCOME_FULL;
            end
         end
         ske_pkg::KIND_READ: begin
            for (int i = 0; i < n && slot < 0; i++)
               if (tbl_client[i] == r.client_id && tbl_server[i] == r.server_id)
                  slot = i;
            if (slot >= 0) begin
               res.outcome   = ske_pkg::OUTCOME_OK;
               res.client_id = tbl_client[slot];
               res.server_id = tbl_server[slot];
               res.key_id    = tbl_key_id[slot];
               res.status    = tbl_status[slot];
               res.key_value = tbl_key[slot];
            end
         end
         ske_pkg::KIND_UPDATE: begin
            for (int i = 0; i < n && slot < 0; i++)
               if (tbl_key_id[i] == r.key_id)
                  slot = i;
            if (slot >= 0) begin
               tbl_status[slot] = r.status_value;
               res.outcome = ske_pkg::OUTCOME_OK;
            end
         end
         default: begin
            // unused kind: table untouched, no match reported
         end
      endcase
      return res;
   endfunction

   function automatic logic [IDW-1:0] random_id();
      int unsigned roll;
      roll = $urandom_range(9);
      if (roll < 7)
         return IDW'({$urandom, $urandom});
      if (roll < 9)
         return IDW'($urandom_range(3));
      return '1;
   endfunction

   // Mostly well-formed traffic: writes that fill or overwrite, reads and updates that
   // hit what was written, with a share of misses, all-zero writes and unused kinds.
   function automatic key_request_type random_request();
      key_request_type r;
      int unsigned     roll;
      int unsigned     pick;
      r.client_id    = random_id();
      r.server_id    = random_id();
      r.key_id       = KIDW'($urandom);
      r.status_value = STW'($urandom_range(255));
      r.key_value    = KEYW'({$urandom, $urandom});
      roll = $urandom_range(99);
      if (roll < 40) begin
         r.kind = ske_pkg::KIND_WRITE;
         if (known_clients.size() > 0 && $urandom_range(2) == 0) begin
            pick = $urandom_range(known_clients.size() - 1);
            r.client_id = known_clients[pick];
            r.server_id = known_servers[pick];
         end else if ($urandom_range(19) == 0) begin
            r = '0;
            r.kind = ske_pkg::KIND_WRITE;
         end
         known_clients.push_back(r.client_id);
         known_servers.push_back(r.server_id);
         known_key_ids.push_back(r.key_id);
         if (known_clients.size() > 96) begin
            void'(known_clients.pop_front());
            void'(known_servers.pop_front());
            void'(known_key_ids.pop_front());
         end
      end else if (roll < 75) begin
         r.kind = ske_pkg::KIND_READ;
         if (known_clients.size() > 0 && $urandom_range(9) < 8) begin
            pick = $urandom_range(known_clients.size() - 1);
            r.client_id = known_clients[pick];
            // now and then keep the client and miss on the server
            r.server_id = ($urandom_range(7) == 0) ? random_id() : known_servers[pick];
         end
      end else if (roll < 95) begin
         r.kind = ske_pkg::KIND_UPDATE;
         if (known_key_ids.size() > 0 && $urandom_range(3) != 0)
            r.key_id = known_key_ids[$urandom_range(known_key_ids.size() - 1)];
         else if ($urandom_range(3) == 0)
            r.key_id = '0;
      end else begin
         r.kind = KIND_UNUSED;
      end
      return r;
   endfunction

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   task automatic push_request(logic [1:0] kind, logic [IDW-1:0] cid, logic [IDW-1:0] sid,
                               logic [KIDW-1:0] kid, logic [STW-1:0] st,
                               logic [KEYW-1:0] key);
      key_request_type r;
      r.kind         = kind;
      r.client_id    = cid;
      r.server_id    = sid;
      r.key_id       = kid;
      r.status_value = st;
      r.key_value    = key;
      queued_requests.push_back(r);
   endtask

   // Block until every queued request has been taken and answered, then let the
   // scan pipeline settle; look again afterwards, since the driver may pick up the
   // last queued item in the same time step as the first look.
   task automatic wait_until_idle();
      do begin
         while (queued_requests.size() != 0 || req_valid || awaited_responses.size() != 0)
            @(negedge clock);
         repeat (SETTLE_CYCLES) @(posedge clock);
      end while (queued_requests.size() != 0 || req_valid || awaited_responses.size() != 0);
   endtask

   task automatic set_slots_in_use(logic [CFGW-1:0] value);
      @(negedge clock);
      csr_valid          <= 1'b1;
      csr_entries_in_use <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      slots_in_use = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(logic [CFGW-1:0] slot_count, int unsigned count);
      wait_until_idle();
      set_slots_in_use(slot_count);
      repeat (count) queued_requests.push_back(random_request());
   endtask

   // Request driver: present the next queued transaction once the previous one has
   // been accepted; hold valid and payload steady until then.
   always @(negedge clock) begin : request_driver
      key_request_type r;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_accept_count == req_offer_count) begin
         if (queued_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            r = queued_requests.pop_front();
            req_kind         <= r.kind;
            req_client_id    <= r.client_id;
            req_server_id    <= r.server_id;
            req_key_id       <= r.key_id;
            req_status_value <= r.status_value;
            req_key_value    <= r.key_value;
            req_valid        <= 1'b1;
            req_offer_count  <= req_offer_count + 1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response receiver: random backpressure, plus one long hold-off per pressure
   // request so the result register fills and the block stalls its input.
   always @(negedge clock) begin : response_receiver
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (pressure_seen != pressure_token) begin
         pressure_seen <= pressure_token;
         hold_left     <= HOLD_OFF_CYCLES;
         rsp_ready     <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Monitor: check the response first, so a result and a new request in the same
   // cycle never pair up; then predict the newly accepted request.
   always @(posedge clock) begin : table_monitor
      key_request_type  r;
      key_response_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_responses.size() == 0) begin
               $error("response with no outstanding request: outcome %0d", rsp_outcome);
               mismatch_count++;
            end else begin
               want = awaited_responses.pop_front();
               check_field("outcome", 64'(want.outcome), 64'(rsp_outcome));
               check_field("found_client_id", 64'(want.client_id), 64'(rsp_found_client_id));
               check_field("found_server_id", 64'(want.server_id), 64'(rsp_found_server_id));
               check_field("found_key_id", 64'(want.key_id), 64'(rsp_found_key_id));
               check_field("found_status", 64'(want.status), 64'(rsp_found_status));
               check_field("found_key_value", 64'(want.key_value), 64'(rsp_found_key_value));
            end
         end
         if (req_valid && req_ready) begin
            r.kind         = req_kind;
            r.client_id    = req_client_id;
            r.server_id    = req_server_id;
            r.key_id       = req_key_id;
            r.status_value = req_status_value;
            r.key_value    = req_key_value;
            awaited_responses.push_back(apply_table_request(r));
            req_accept_count <= req_accept_count + 1;
         end
      end
   end

   // Watchdog: abort when no channel has moved a transaction for too long.
   always @(posedge clock) begin : stall_watchdog
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d idle cycles", stall_cycles);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin : stimulus
      for (int i = 0; i < DEPTH; i++) begin
         tbl_client[i] = '0;
         tbl_server[i] = '0;
         tbl_key_id[i] = '0;
         tbl_status[i] = '0;
         tbl_key[i]    = '0;
      end
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part at the reset slot count. Empty slots match both-zero ids and
      // key id zero; an all-zero write must leave its slot counted as empty.
      push_request(ske_pkg::KIND_READ,   '0, '0, '0, '0, '0);
      push_request(ske_pkg::KIND_UPDATE, '0, '0, '0, 8'h5A, '0);
      push_request(ske_pkg::KIND_READ,   '0, '0, '0, '0, '0);
      push_request(ske_pkg::KIND_WRITE,  '0, '0, '0, '0, '0);
      push_request(ske_pkg::KIND_WRITE,  '1, '1, '1, '1, '1);
      push_request(ske_pkg::KIND_READ,   '1, '1, '0, '0, '0);
      push_request(ske_pkg::KIND_UPDATE, '0, '0, '1, '0, '0);
      push_request(ske_pkg::KIND_READ,   '1, '1, '0, '0, '0);
      push_request(ske_pkg::KIND_WRITE,  IDW'(1), '0, KIDW'(1), 8'h01,
                   KEYW'(64'h0123_4567_89AB_CDEF));
      push_request(ske_pkg::KIND_WRITE,  IDW'(1), '0, KIDW'(2), 8'h02,
                   KEYW'(64'hFEDC_BA98_7654_3210));
      push_request(ske_pkg::KIND_READ,   IDW'(1), IDW'(1), '0, '0, '0);
      push_request(ske_pkg::KIND_READ,   IDW'(1), '0, '0, '0, '0);
      push_request(ske_pkg::KIND_UPDATE, '0, '0, KIDW'(12345), 8'h77, '0);
      push_request(ske_pkg::KIND_UPDATE, '0, '0, '0, '0, '0);
      push_request(KIND_UNUSED, '1, '1, '1, '1, '1);
      push_request(ske_pkg::KIND_WRITE,  IDW'(64'hAAAA_AAAA_AAAA_AAAA),
                   IDW'(64'h5555_5555_5555_5555),
                   KIDW'(31'h2AAA_AAAA), 8'h55, KEYW'(64'h5555_5555_5555_5555));
      push_request(ske_pkg::KIND_READ,   IDW'(64'hAAAA_AAAA_AAAA_AAAA),
                   IDW'(64'h5555_5555_5555_5555), '0, '0, '0);
      repeat (150) queued_requests.push_back(random_request());

      // Slow sender, slow receiver; count above the table depth, then zero slots
      run_phase(7'd127, 150);
      run_phase(7'd0, 30);

      // Swap the idle rates; small tables fill up and report full
      send_idle_pct = 61;
      recv_idle_pct = 32;
      run_phase(7'd1, 80);
      run_phase(7'd6, 200);
      run_phase(7'd64, 250);
      pressure_token++;

      // Full speed on both sides
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_phase(7'd63, 150);
      run_phase(CFGW'($urandom_range(70, 2)), 190);

      wait_until_idle();
      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
